// ----- rtl/weighted_round_robin_scheduler_defines.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef WEIGHTED_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define WEIGHTED_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ----- rtl/wrr_pkg.sv -----
// Package with the sizes, the job entry type and the cell control type of the scheduler.
package wrr_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ID_W     = 8;
  localparam int REM_W    = 16;
  localparam int WGT_W    = 8;
  localparam int USED_W   = 8;
  localparam int TICK_W   = 32;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REM_W-1:0] remaining;
    logic [WGT_W-1:0] weight;
  } entry_t;

  // Per-cell controls for one tick.
  typedef struct packed {
    logic arr;    // the arriving job lands in this cell
    logic sel;    // this cell holds the served job
    logic shift;  // take the upper neighbor's entry (removal below or here)
  } cell_ctl_t;

endpackage

// ----- rtl/wrr_in_if.sv -----
// Input channel: one scheduler tick with an optional arriving job.
interface wrr_in_if;
  logic       valid;
  logic       ready;
  logic       arrive_valid;
  logic [7:0] arrive_id;
  logic [15:0] arrive_length;
  logic [7:0] arrive_weight;

  modport source (output valid, output arrive_valid, output arrive_id,
                  output arrive_length, output arrive_weight, input ready);
  modport sink   (input valid, input arrive_valid, input arrive_id,
                  input arrive_length, input arrive_weight, output ready);
endinterface

// ----- rtl/wrr_out_if.sv -----
// Output channel: the result of one scheduler tick.
interface wrr_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [7:0]  served_id;
  logic [15:0] served_remaining;
  logic        finished;
  logic [31:0] finish_time;
  logic        arrival_dropped;

  modport source (output valid, output ran, output served_id, output served_remaining,
                  output finished, output finish_time, output arrival_dropped,
                  input ready);
  modport sink   (input valid, input ran, input served_id, input served_remaining,
                  input finished, input finish_time, input arrival_dropped,
                  output ready);
endinterface

// ----- rtl/wrr_cell.sv -----
// One job table cell: holds one entry, takes an arrival, decrements or shifts down.
module wrr_cell (
  input  logic               clk_i,
  input  wrr_pkg::cell_ctl_t ctl_i,
  input  wrr_pkg::entry_t    new_i,
  input  wrr_pkg::entry_t    nb_i,
  output wrr_pkg::entry_t    eff_o
);
  import wrr_pkg::*;

  entry_t entry_q, entry_d;

  // An arrival into this cell is visible to the same tick.
  assign eff_o = ctl_i.arr ? new_i : entry_q;

  always_comb begin
    entry_d = eff_o;
    if (ctl_i.shift) begin
      entry_d = nb_i;
    end else if (ctl_i.sel && (eff_o.remaining != '0)) begin
      entry_d.remaining = eff_o.remaining - REM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- rtl/weighted_round_robin_scheduler.sv -----
// Weighted round-robin scheduler: a tick's result beat is registered for the next cycle.
// Throughput: one tick per cycle; a tick is taken whenever the output register is
// empty or its beat is taken in the same cycle, so the rate is set by the sink alone.
// The whole tick (append, slot choice, service, removal) resolves in the cell row at once.
// Reset (rst_ni low, asynchronous) empties the table, zeroes slot, use count and tick
// count, and drops any pending result beat; cell contents stay undefined until written.
`include "weighted_round_robin_scheduler_defines.svh"

module weighted_round_robin_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrr_in_if.sink    in_i,
  wrr_out_if.source out_o
);
  import wrr_pkg::*;

  // Control state of the scheduler. The job table itself lives in the cell row.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  // Result register, which parts the input side from the output side.
  logic              out_valid_q, out_valid_d;
  logic              ran_q, fin_q, drop_q;
  logic [ID_W-1:0]   id_q;
  logic [REM_W-1:0]  rem_q;
  logic [TICK_W-1:0] ftime_q;

  logic              accept;
  logic              arr_ok, drop;
  logic [CNT_W-1:0]  count_a;
  logic              active;
  logic [WGT_W-1:0]  w_cur;
  logic              adv;
  logic [CNT_W-1:0]  s_ext;
  logic [SLOT_W-1:0] s;
  logic [USED_W-1:0] used_base;
  entry_t            served;
  logic [REM_W-1:0]  r;
  logic              fin;
  entry_t            new_entry;
  entry_t            eff   [MAX_JOBS];
  entry_t            nb    [MAX_JOBS];
  cell_ctl_t         ctl   [MAX_JOBS];

  // A new tick enters whenever the result register is free or is drained now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign new_entry.id        = in_i.arrive_id;
  assign new_entry.remaining = in_i.arrive_length;
  assign new_entry.weight    = in_i.arrive_weight;

  // The arrival is handled first: it is appended at the end of the table, or it is
  // refused when the table is full. The rest of the tick sees the grown table.
  assign arr_ok  = in_i.arrive_valid && (count_q < CNT_W'(MAX_JOBS));
  assign drop    = in_i.arrive_valid && !arr_ok;
  assign count_a = count_q + CNT_W'(arr_ok);
  assign active  = (count_a != '0);

  // Slot choice. The current job gives up the slot once it has used its weight in
  // ticks; the slot then steps on, and wraps to the first entry past the table end.
  // A slot that already lies beyond the table (after its last entry was removed)
  // just wraps without a turn check.
  always_comb begin
    w_cur  = '0;
    served = '0;
    for (int k = 0; k < MAX_JOBS; k++) begin
      if (cur_q == SLOT_W'(k)) begin
        w_cur = eff[k].weight;
      end
    end
    adv   = ((CNT_W'(cur_q) < count_a) && (USED_W'(w_cur) <= used_q));
    s_ext = CNT_W'(cur_q) + CNT_W'(adv);
    s     = (s_ext >= count_a) ? '0 : SLOT_W'(s_ext);
    for (int k = 0; k < MAX_JOBS; k++) begin
      if (s == SLOT_W'(k)) begin
        served = eff[k];
      end
    end
  end

  // Service: the served job's remaining length counts down and stops at zero.
  // Reaching zero completes the job and removes it from the table.
  assign r   = (served.remaining != '0) ? served.remaining - REM_W'(1) : '0;
  assign fin = active && (r == '0);

  // The use count restarts at a hand-over, saturates, and restarts after a removal
  // so that the entry that shifts into the slot begins a fresh turn.
  assign used_base = adv ? '0 : used_q;

  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    used_d  = used_q;
    tick_d  = tick_q;
    if (accept) begin
      count_d = count_a - CNT_W'(fin);
      tick_d  = tick_q + TICK_W'(1);
      if (active) begin
        cur_d = s;
        if (fin) begin
          used_d = '0;
        end else if (used_base != '1) begin
          used_d = used_base + USED_W'(1);
        end else begin
          used_d = used_base;
        end
      end
    end
  end

  // The cell row. Every cell hands its current entry down to its lower neighbor, so
  // a removal shifts all later entries down by one in the same cycle. The top cell
  // has no upper neighbor; what it takes in is never read before it is written.
  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    if (k == MAX_JOBS - 1) begin : g_top
      assign nb[k] = '0;
    end else begin : g_mid
      assign nb[k] = eff[k+1];
    end

    assign ctl[k].arr   = accept && arr_ok && (count_q == CNT_W'(k));
    assign ctl[k].sel   = accept && active && (s == SLOT_W'(k));
    assign ctl[k].shift = accept && fin && (CNT_W'(s) <= CNT_W'(k));

    wrr_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl[k]),
      .new_i (new_entry),
      .nb_i  (nb[k]),
      .eff_o (eff[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_q       <= '0;
      used_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload. On an empty table every service field reads zero, and the
  // finish time is zero unless the served job completed on this tick.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ran_q   <= active;
      id_q    <= active ? served.id : '0;
      rem_q   <= active ? r : '0;
      fin_q   <= fin;
      ftime_q <= fin ? tick_q + TICK_W'(1) : '0;
      drop_q  <= drop;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.ran              = ran_q;
  assign out_o.served_id        = id_q;
  assign out_o.served_remaining = rem_q;
  assign out_o.finished         = fin_q;
  assign out_o.finish_time      = ftime_q;
  assign out_o.arrival_dropped  = drop_q;

  `WRR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_JOBS))
  `WRR_ASSERT_NOW(a_drop_full, accept && drop, count_q == CNT_W'(MAX_JOBS))
  `WRR_ASSERT_NOW(a_fin_ran, out_valid_q && fin_q, ran_q && (rem_q == '0))
  `WRR_ASSERT_NEXT(a_result_next, accept, out_valid_q)
  `WRR_ASSERT_NEXT(a_fin_shrinks, accept && fin && !arr_ok, count_q == $past(count_q) - CNT_W'(1))

endmodule
